@@ hdl/swinging_door_compressor_defines.svh @@
// ---------------------------------------------------------------------------
// Swinging door compressor assertion macros
// Shared concurrent assertion forms for the compressor RTL.
// ---------------------------------------------------------------------------
`ifndef SWINGING_DOOR_COMPRESSOR_DEFINES_SVH
`define SWINGING_DOOR_COMPRESSOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sdc_pkg.sv @@
// ---------------------------------------------------------------------------
// Swinging door compressor package
// Widths, register indexes and reset values shared by the compressor files.
// ---------------------------------------------------------------------------
package sdc_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT  = 48;

   localparam int SLOPE_BITS    = 64;
   localparam int FRAC_BITS     = 32;
   localparam int DEV_BITS      = 31;
   localparam int INTERVAL_BITS = 32;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOOR_DEVIATION     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_STORE_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STORE_INTERVAL = 2'd2;

   localparam logic [DEV_BITS-1:0]      DEV_RESET = 31'd32768;
   localparam logic [INTERVAL_BITS-1:0] MIN_RESET = 32'd0;
   localparam logic [INTERVAL_BITS-1:0] MAX_RESET = 32'd28800000;

   localparam logic signed [SLOPE_BITS-1:0] SLOPE_MAX = {1'b0, {(SLOPE_BITS-1){1'b1}}};
   localparam logic signed [SLOPE_BITS-1:0] SLOPE_MIN = {1'b1, {(SLOPE_BITS-1){1'b0}}};

endpackage

@@ hdl/sdc_divider.sv @@
// ---------------------------------------------------------------------------
// Swinging door slope divider
// Bit-serial restoring divider that forms trunc(diff * 2^32 / dt) with
// saturation to the signed 64-bit range, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sdc_divider #(
   parameter int DIFF_BITS = 34,
   parameter int TIME_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [DIFF_BITS-1:0]          diff,
   input  logic        [TIME_BITS-1:0]          divisor,
   output logic                                 done,
   output logic signed [sdc_pkg::SLOPE_BITS-1:0] slope
);
   import sdc_pkg::*;

   localparam int ITERS    = DIFF_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(ITERS + 1);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic                         neg_ff;
   logic [DIFF_BITS-1:0]         dividend_ff;
   logic [TIME_BITS-1:0]         divisor_ff;
   logic [TIME_BITS:0]           rem_ff;
   logic [SLOPE_BITS-1:0]        quot_ff;
   logic                         ovf_ff;
   logic signed [SLOPE_BITS-1:0] slope_ff;

   logic [DIFF_BITS-1:0]         magnitude;
   logic [TIME_BITS:0]           rem_shift;
   logic                         take;
   logic [TIME_BITS:0]           rem_in;
   logic                         sat;
   logic signed [SLOPE_BITS-1:0] slope_in;

   assign magnitude = diff[DIFF_BITS-1] ? (~diff + DIFF_BITS'(1)) : diff;
   assign rem_shift = {rem_ff[TIME_BITS-1:0], dividend_ff[DIFF_BITS-1]};
   assign take      = rem_shift >= {1'b0, divisor_ff};
   assign rem_in    = take ? (rem_shift - {1'b0, divisor_ff}) : rem_shift;

   assign sat = ovf_ff | quot_ff[SLOPE_BITS-1];

   always_comb begin
      if (neg_ff) begin
         slope_in = sat ? SLOPE_MIN : -$signed(quot_ff);
      end else begin
         slope_in = sat ? SLOPE_MAX : $signed(quot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(ITERS);
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - CNT_BITS'(1);
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff      <= diff[DIFF_BITS-1];
         dividend_ff <= magnitude;
         divisor_ff  <= divisor;
         rem_ff      <= '0;
         quot_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            dividend_ff <= {dividend_ff[DIFF_BITS-2:0], 1'b0};
            rem_ff      <= rem_in;
            ovf_ff      <= ovf_ff | quot_ff[SLOPE_BITS-1];
            quot_ff     <= {quot_ff[SLOPE_BITS-2:0], take};
         end else begin
            slope_ff <= slope_in;
         end
      end
   end

   assign done  = done_ff;
   assign slope = slope_ff;

endmodule

@@ hdl/swinging_door_compressor.sv @@
// Each accepted sample first passes the check step; the first sample after reset is then
// offered as a stored point by the first-sample step, a sample whose time does not advance
// is ignored, and any other sample runs the bit-serial slope dividers and the decide step,
// which stores points and, when a pivot store reopens the doors, runs the dividers again.
// One sample is taken at a time, only in the idle state, and a full queue adds stalls.
// Reset clears the trend state and the result queue and loads the register defaults.
// ---------------------------------------------------------------------------
// Swinging door compressor
// Swinging door trending over timestamped Q16.16 samples, emitting the points to
// archive through a two-entry result queue.
// ---------------------------------------------------------------------------
`include "swinging_door_compressor_defines.svh"

module swinging_door_compressor #(
   parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEFAULT,
   parameter int TIME_BITS  = sdc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample_value, sample_time
   input  logic [((VALUE_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // force_store
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // point_value, point_time
   output logic [((VALUE_BITS+TIME_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sdc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sdc_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import sdc_pkg::*;

   localparam int TDATA_BITS = ((VALUE_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int DIFF_BITS  = ((VALUE_BITS > DEV_BITS) ? VALUE_BITS : DEV_BITS) + 2;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_FIRST  = 3'd2;
   localparam logic [2:0] S_DIV1   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_DIV2   = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic                         started_ff;
   logic [DEV_BITS-1:0]          dev_ff;
   logic [INTERVAL_BITS-1:0]     min_ff;
   logic [INTERVAL_BITS-1:0]     max_ff;

   logic signed [VALUE_BITS-1:0] samp_value_ff;
   logic [TIME_BITS-1:0]         samp_time_ff;
   logic                         samp_force_ff;
   logic signed [VALUE_BITS-1:0] anchor_value_ff;
   logic [TIME_BITS-1:0]         anchor_time_ff;
   logic signed [VALUE_BITS-1:0] pivot_value_ff;
   logic [TIME_BITS-1:0]         pivot_time_ff;
   logic signed [SLOPE_BITS-1:0] upper_ff;
   logic signed [SLOPE_BITS-1:0] lower_ff;
   logic [TIME_BITS-1:0]         dt_ff;
   logic                         max_hit_ff;
   logic                         force_ff;

   logic [VALUE_BITS-1:0]        fifo_value_ff [2];
   logic [TIME_BITS-1:0]         fifo_time_ff  [2];
   logic                         fifo_last_ff  [2];
   logic [VALUE_BITS-1:0]        fifo_value_in [2];
   logic [TIME_BITS-1:0]         fifo_time_in  [2];
   logic                         fifo_last_in  [2];
   logic [1:0]                   count_ff, count_in;

   logic                         req_fire;
   logic                         pop;
   logic [1:0]                   base;
   logic [TIME_BITS-1:0]         dt_now;
   logic                         max_hit_now;
   logic                         advancing;
   logic                         closed;
   logic                         store_hit;
   logic                         too_soon;
   logic                         two;
   logic [1:0]                   push_cnt;
   logic                         room;
   logic                         commit;
   logic                         reopen;
   logic                         first_push;
   logic [1:0]                   push_n;
   logic [VALUE_BITS-1:0]        p0_value;
   logic [TIME_BITS-1:0]         p0_time;
   logic                         p0_last;

   logic signed [DIFF_BITS-1:0]  v_ext;
   logic signed [DIFF_BITS-1:0]  a_ext;
   logic signed [DIFF_BITS-1:0]  dev_ext;
   logic signed [DIFF_BITS-1:0]  diff_upper;
   logic signed [DIFF_BITS-1:0]  diff_lower;
   logic [TIME_BITS-1:0]         div_divisor;
   logic                         div_start;
   logic                         div_u_done;
   logic                         div_l_done;
   logic signed [SLOPE_BITS-1:0] slope_u;
   logic signed [SLOPE_BITS-1:0] slope_l;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = TDATA_BITS'({fifo_time_ff[0], fifo_value_ff[0]});
   assign rsp_tlast  = fifo_last_ff[0];
   assign pop        = rsp_tvalid & rsp_tready;

   assign dt_now      = samp_time_ff - anchor_time_ff;
   assign max_hit_now = (max_ff != '0) && (dt_now >= TIME_BITS'(max_ff));
   assign advancing   = samp_time_ff > anchor_time_ff;

   assign closed    = upper_ff < lower_ff;
   assign store_hit = closed | max_hit_ff | force_ff;
   assign too_soon  = dt_ff < TIME_BITS'(min_ff);
   assign two       = force_ff && (pivot_time_ff != samp_time_ff);
   assign push_cnt  = two ? 2'd2 : 2'd1;
   assign room      = ({1'b0, count_ff} + {1'b0, push_cnt}) <= 3'd2;
   assign commit    = (state_ff == S_DECIDE) && store_hit && !too_soon && room;
   assign reopen    = !two && (samp_time_ff > pivot_time_ff);
   assign first_push = (state_ff == S_FIRST) && (count_ff != 2'd2);

   assign v_ext   = DIFF_BITS'(samp_value_ff);
   assign a_ext   = (state_ff == S_DECIDE) ? DIFF_BITS'(pivot_value_ff)
                                           : DIFF_BITS'(anchor_value_ff);
   assign dev_ext = DIFF_BITS'(dev_ff);
   assign diff_upper = v_ext - (a_ext + dev_ext);
   assign diff_lower = v_ext - (a_ext - dev_ext);
   assign div_divisor = (state_ff == S_DECIDE) ? (samp_time_ff - pivot_time_ff) : dt_now;
   assign div_start = ((state_ff == S_CHECK) && started_ff && advancing) || (commit && reopen);

   sdc_divider #(
      .DIFF_BITS (DIFF_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_div_upper (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (diff_upper),
      .divisor (div_divisor),
      .done    (div_u_done),
      .slope   (slope_u)
   );

   sdc_divider #(
      .DIFF_BITS (DIFF_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_div_lower (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (diff_lower),
      .divisor (div_divisor),
      .done    (div_l_done),
      .slope   (slope_l)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!started_ff) state_in = S_FIRST;
            else if (!advancing) state_in = S_IDLE;
            else state_in = S_DIV1;
         end
         S_FIRST: begin
            if (first_push) state_in = S_IDLE;
         end
         S_DIV1: begin
            if (div_u_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!store_hit || too_soon) state_in = S_IDLE;
            else if (room) state_in = reopen ? S_DIV2 : S_IDLE;
         end
         S_DIV2: begin
            if (div_u_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == S_FIRST) begin
         p0_value = samp_value_ff;
         p0_time  = samp_time_ff;
         p0_last  = 1'b1;
      end else begin
         p0_value = pivot_value_ff;
         p0_time  = pivot_time_ff;
         p0_last  = !two;
      end
      if (first_push) push_n = 2'd1;
      else if (commit) push_n = push_cnt;
      else push_n = 2'd0;
      base = count_ff - {1'b0, pop};
      fifo_value_in = fifo_value_ff;
      fifo_time_in  = fifo_time_ff;
      fifo_last_in  = fifo_last_ff;
      if (pop) begin
         fifo_value_in[0] = fifo_value_ff[1];
         fifo_time_in[0]  = fifo_time_ff[1];
         fifo_last_in[0]  = fifo_last_ff[1];
      end
      if (push_n != 2'd0) begin
         fifo_value_in[base[0]] = p0_value;
         fifo_time_in[base[0]]  = p0_time;
         fifo_last_in[base[0]]  = p0_last;
      end
      if (push_n == 2'd2) begin
         fifo_value_in[1] = samp_value_ff;
         fifo_time_in[1]  = samp_time_ff;
         fifo_last_in[1]  = 1'b1;
      end
      count_in = base + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         started_ff <= 1'b0;
         count_ff   <= 2'd0;
         dev_ff     <= DEV_RESET;
         min_ff     <= MIN_RESET;
         max_ff     <= MAX_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (first_push) started_ff <= 1'b1;
         if (csr_valid) begin
            case (csr_index)
               CSR_DOOR_DEVIATION:     dev_ff <= csr_data[DEV_BITS-1:0];
               CSR_MIN_STORE_INTERVAL: min_ff <= csr_data[INTERVAL_BITS-1:0];
               CSR_MAX_STORE_INTERVAL: max_ff <= csr_data[INTERVAL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      fifo_value_ff <= fifo_value_in;
      fifo_time_ff  <= fifo_time_in;
      fifo_last_ff  <= fifo_last_in;
      if (req_fire) begin
         samp_value_ff <= req_tdata[VALUE_BITS-1:0];
         samp_time_ff  <= req_tdata[VALUE_BITS +: TIME_BITS];
         samp_force_ff <= req_tuser;
      end
      if ((state_ff == S_CHECK) && started_ff && advancing) begin
         dt_ff      <= dt_now;
         max_hit_ff <= max_hit_now;
         force_ff   <= samp_force_ff | ((dev_ff != '0) & max_hit_now);
      end
      if (first_push) begin
         anchor_value_ff <= samp_value_ff;
         anchor_time_ff  <= samp_time_ff;
         pivot_value_ff  <= samp_value_ff;
         pivot_time_ff   <= samp_time_ff;
         upper_ff        <= SLOPE_MAX;
         lower_ff        <= SLOPE_MIN;
      end
      if ((state_ff == S_DIV1) && div_u_done) begin
         if (slope_u < upper_ff) upper_ff <= slope_u;
         if (slope_l > lower_ff) lower_ff <= slope_l;
      end
      if ((state_ff == S_DECIDE) && !store_hit) begin
         pivot_value_ff <= samp_value_ff;
         pivot_time_ff  <= samp_time_ff;
      end
      if (commit) begin
         upper_ff       <= SLOPE_MAX;
         lower_ff       <= SLOPE_MIN;
         pivot_value_ff <= samp_value_ff;
         pivot_time_ff  <= samp_time_ff;
         if (two) begin
            anchor_value_ff <= samp_value_ff;
            anchor_time_ff  <= samp_time_ff;
         end else begin
            anchor_value_ff <= pivot_value_ff;
            anchor_time_ff  <= pivot_time_ff;
         end
      end
      if ((state_ff == S_DIV2) && div_u_done) begin
         upper_ff <= slope_u;
         lower_ff <= slope_l;
      end
   end

   `SDC_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= 2'd2,
      "result queue holds more than two points")
   `SDC_ASSERT_NEXT(a_accept_check, clock, reset, req_fire, state_ff == S_CHECK,
      "accepted sample did not move to the check step")
   `SDC_ASSERT_SAME(a_div_lockstep, clock, reset, 1'b1, div_u_done == div_l_done,
      "slope dividers finished in different cycles")
   `SDC_ASSERT_SAME(a_div_started, clock, reset,
      (state_ff == S_DIV1) || (state_ff == S_DIV2), started_ff,
      "slope division runs before the first sample was stored")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Swinging door compressor testbench
// Drives timestamped samples into the compressor and predicts every archived
// point with a behavioral copy of the door algorithm. It runs directed corner
// samples and then random trends under several register settings with
// sender gaps, receiver stalls and a long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
   import sdc_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [47:0] stamp;
      bit          last;
   } archive_point_type;

   class door_trend_tracker;
      longint            door_dev;
      logic [63:0]       min_gap;
      logic [63:0]       max_gap;
      bit                opened;
      longint            anchor_val;
      logic [63:0]       anchor_ms;
      longint            pivot_val;
      logic [63:0]       pivot_ms;
      longint            upper_bound;
      longint            lower_bound;
      archive_point_type points_due[$];
      int                mismatches;
      int                points_checked;

      function new();
         door_dev       = {33'b0, DEV_RESET};
         min_gap        = {32'b0, MIN_RESET};
         max_gap        = {32'b0, MAX_RESET};
         opened         = 0;
         anchor_val     = 0;
         anchor_ms      = '0;
         pivot_val      = 0;
         pivot_ms       = '0;
         upper_bound    = SLOPE_MAX;
         lower_bound    = SLOPE_MIN;
         mismatches     = 0;
         points_checked = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index, logic [31:0] data);
         case (index)
            CSR_DOOR_DEVIATION:     door_dev = {33'b0, data[30:0]};
            CSR_MIN_STORE_INTERVAL: min_gap = {32'b0, data};
            CSR_MAX_STORE_INTERVAL: max_gap = {32'b0, data};
            default: ;
         endcase
      endfunction

      // Truncated diff * 2^32 / span, clipped to the signed 64-bit range.
      function longint door_slope(longint diff, logic [63:0] span_ms);
         logic [127:0] quotient;
         logic [63:0]  magnitude;
         logic [63:0]  ceiling;
         bit           negative;
         negative  = diff < 0;
         magnitude = negative ? -diff : diff;
         quotient  = ({64'b0, magnitude} << 32) / {64'b0, span_ms};
         ceiling   = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         if (quotient > {64'b0, ceiling})
            quotient = {64'b0, ceiling};
         return negative ? -longint'(quotient[63:0]) : longint'(quotient[63:0]);
      endfunction

      function void archive(longint v, logic [63:0] t, bit last);
         archive_point_type p;
         p.value = v[31:0];
         p.stamp = t[47:0];
         p.last  = last;
         points_due.push_back(p);
      endfunction

      // Returns 0 when the sample is ignored because its time does not advance.
      function bit take_sample(logic [31:0] raw_value, logic [47:0] raw_time, bit forced);
         longint      v;
         longint      su;
         longint      sl;
         logic [63:0] t;
         logic [63:0] dt;
         bit          max_hit;
         bit          closed;
         bit          both;
         v = $signed(raw_value);
         t = {16'b0, raw_time};
         if (!opened) begin
            opened      = 1;
            anchor_val  = v;
            anchor_ms   = t;
            pivot_val   = v;
            pivot_ms    = t;
            upper_bound = SLOPE_MAX;
            lower_bound = SLOPE_MIN;
            archive(v, t, 1);
            return 1;
         end
         if (t <= anchor_ms)
            return 0;
         dt      = t - anchor_ms;
         max_hit = (max_gap != 0) && (dt >= max_gap);
         if (door_dev > 0 && max_hit)
            forced = 1;
         su = door_slope(v - (anchor_val + door_dev), dt);
         sl = door_slope(v - (anchor_val - door_dev), dt);
         if (su < upper_bound)
            upper_bound = su;
         if (sl > lower_bound)
            lower_bound = sl;
         closed = upper_bound < lower_bound;
         if (!(closed || max_hit || forced)) begin
            pivot_val = v;
            pivot_ms  = t;
            return 1;
         end
         if (dt < min_gap)
            return 1;
         both = forced && (pivot_ms != t);
         archive(pivot_val, pivot_ms, !both);
         if (both) begin
            archive(v, t, 1);
            anchor_val = v;
            anchor_ms  = t;
         end else begin
            anchor_val = pivot_val;
            anchor_ms  = pivot_ms;
         end
         upper_bound = SLOPE_MAX;
         lower_bound = SLOPE_MIN;
         pivot_val   = v;
         pivot_ms    = t;
         if (t > anchor_ms) begin
            upper_bound = door_slope(v - (anchor_val + door_dev), t - anchor_ms);
            lower_bound = door_slope(v - (anchor_val - door_dev), t - anchor_ms);
         end
         return 1;
      endfunction

      function void compare_point(logic [31:0] value, logic [47:0] stamp, logic last);
         archive_point_type due;
         points_checked++;
         if (points_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected point, expected none, got value %h time %h last %b",
                     $time, value, stamp, last);
            return;
         end
         due = points_due.pop_front();
         if (due.value !== value) begin
            mismatches++;
            $display("%0t: point value expected %h, got %h", $time, due.value, value);
         end
         if (due.stamp !== stamp) begin
            mismatches++;
            $display("%0t: point time expected %h, got %h", $time, due.stamp, stamp);
         end
         if (due.last !== last) begin
            mismatches++;
            $display("%0t: last of run expected %b, got %b", $time, due.last, last);
         end
      endfunction

      function int pending();
         return points_due.size();
      endfunction
   endclass

   localparam int DATA_BITS    = ((32 + 48 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_CYCLES  = 3000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]      rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   door_trend_tracker tracker;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                hold_request = 0;
   int                cycle_count = 0;
   int                samples_sent = 0;
   int                settings_used = 1;
   logic [47:0]       now_ms;
   logic [31:0]       walk_value;
   bit                processed;

   swinging_door_compressor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.compare_point(rsp_tdata[31:0], rsp_tdata[79:32], rsp_tlast);
   end

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(logic [31:0] dev, logic [31:0] min_ms, logic [31:0] max_ms);
      write_csr(CSR_DOOR_DEVIATION, dev);
      write_csr(CSR_MIN_STORE_INTERVAL, min_ms);
      write_csr(CSR_MAX_STORE_INTERVAL, max_ms);
      settings_used++;
   endtask

   task automatic send_sample(logic [31:0] value, logic [47:0] stamp, bit forced,
                              output bit taken);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {stamp, value};
      req_tuser  = forced;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      taken = tracker.take_sample(value, stamp, forced);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_trend(int target, int span, int force_pct, int jump_pct,
                            logic [63:0] jump_limit);
      int          taken;
      int          roll;
      bit          used;
      logic [63:0] jump;
      logic [31:0] value;
      logic [47:0] stamp;
      taken = 0;
      while (taken < target) begin
         roll = $urandom_range(99);
         jump = {$urandom, $urandom} % jump_limit + 1;
         if (roll < 6) begin
            stamp = now_ms - $urandom_range(0, 200);
         end else begin
            if (roll < 6 + jump_pct)
               now_ms = now_ms + jump[47:0];
            else
               now_ms = now_ms + $urandom_range(1, 40);
            stamp = now_ms;
         end
         walk_value = walk_value + $urandom_range(0, 2 * span) - span;
         value = ($urandom_range(99) < 8) ? $urandom : walk_value;
         send_sample(value, stamp, $urandom_range(99) < force_pct, used);
         if (used)
            taken++;
      end
   endtask

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_sample(32'h0000_0000, 48'd1000, 1'b0, processed);
      send_sample(32'h0000_0005, 48'd1000, 1'b0, processed);
      send_sample(32'h0000_0005, 48'd400, 1'b0, processed);
      send_sample(32'h0000_0064, 48'd1010, 1'b0, processed);
      send_sample(32'h7FFF_FFFF, 48'd1020, 1'b0, processed);
      send_sample(32'hFFFF_FFFB, 48'd1020, 1'b1, processed);
      send_sample(32'h8000_0000, 48'd1021, 1'b0, processed);
      send_sample(32'h7FFF_FFFF, 48'd1022, 1'b0, processed);
      send_sample(32'h0000_0003, 48'd2000, 1'b1, processed);
      send_sample(32'h0000_0007, 48'd28_802_100, 1'b0, processed);
      settle();

      configure(32'd0, 32'd0, 32'd1000);
      send_sample(32'd0, 48'd29_000_000, 1'b1, processed);
      send_sample(32'd0, 48'd29_000_100, 1'b0, processed);
      send_sample(32'd1000, 48'd29_000_050, 1'b0, processed);
      send_sample(32'd1000, 48'd29_000_200, 1'b0, processed);
      send_sample(32'd0, 48'd29_001_500, 1'b0, processed);
      settle();

      configure(32'd0, 32'd500, 32'd0);
      send_sample(32'd0, 48'd29_100_000, 1'b1, processed);
      send_sample(32'd5000, 48'd29_100_100, 1'b1, processed);
      send_sample(32'd5000, 48'd29_100_600, 1'b1, processed);
      settle();

      now_ms     = 48'd29_200_000;
      walk_value = '0;

      configure(32'd131072, 32'd0, 32'd0);
      send_idle_pct = 58;
      run_trend(250, 200000, 5, 5, 64'd100000);
      settle();

      configure(32'd0, 32'd0, 32'd5000);
      send_idle_pct  = 0;
      recv_stall_pct = 58;
      run_trend(200, 5000, 5, 5, 64'd8000);
      settle();

      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      recv_stall_pct = 0;
      run_trend(100, 1 << 24, 5, 30, 64'd1 << 33);
      settle();

      configure($urandom_range(1, 1 << 20), $urandom_range(5, 60), $urandom_range(200, 3000));
      send_idle_pct  = 7;
      recv_stall_pct = 7;
      hold_request   = 1;
      run_trend(250, 60000, 10, 5, 64'd5000);
      settle();

      configure(32'd1, 32'd0, 32'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_trend(150, 3, 5, 5, 64'd100);
      settle();

      configure(32'd32768, 32'd0, 32'd28_800_000);
      recv_stall_pct = 58;
      run_trend(250, 50000, 5, 3, 64'd40_000_000);
      send_sample(32'h1234_5678, 48'hFFFF_FFFF_0000, 1'b0, processed);
      send_sample(32'h0000_8000, 48'hFFFF_FFFF_0010, 1'b0, processed);
      send_sample(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, processed);
      settle();

      $display("Covered %0d samples and %0d archived points over %0d register settings,",
               samples_sent, tracker.points_checked, settings_used);
      $display("with sender gaps, receiver stalls and one long output hold-off.");
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
